### src/pwd_pkg.sv
// Package for the pulse-width demodulator: widths, payload and event types,
// class bounds, and the helper functions that derive the bounds.
// No dependencies.
package pwd_pkg;

   // Width of every sample count and configuration register.
   localparam int WIDTH_BITS = 20;
   // Signed bound width: holds nominal minus tolerance and nominal plus tolerance.
   localparam int BOUND_BITS = WIDTH_BITS + 2;
   // Configuration register index width.
   localparam int CSR_INDEX_BITS = 3;

   typedef logic [WIDTH_BITS-1:0] width_type;
   typedef logic signed [BOUND_BITS-1:0] bound_type;

   // Larger than any pulse width: stands for a class without an upper limit.
   localparam bound_type BOUND_MAX = {1'b0, {(BOUND_BITS-1){1'b1}}};

   // Event codes on the result channel.
   typedef enum logic [2:0] {
      EV_ZERO = 3'd0,
      EV_ONE  = 3'd1,
      EV_SYNC = 3'd2,
      EV_ROW  = 3'd3,
      EV_EOM  = 3'd4
   } event_kind_type;

   // Configuration register indexes.
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_SHORT_WIDTH = 3'd0,
      CSR_LONG_WIDTH  = 3'd1,
      CSR_SYNC_WIDTH  = 3'd2,
      CSR_TOLERANCE   = 3'd3,
      CSR_EOM_GAP     = 3'd4,
      CSR_ROW_GAP     = 3'd5
   } csr_index_type;

   // Input transaction payload.
   typedef struct packed {
      width_type pulse_width;
      width_type gap_width;
      logic      final_pulse;
   } req_type;

   // Result transaction payload.
   typedef struct packed {
      event_kind_type event_kind;
      logic           last_of_run;
   } rsp_type;

   // Exclusive class bounds: a pulse p is in a class when lo < p < hi.
   typedef struct packed {
      bound_type one_l;
      bound_type one_u;
      bound_type zero_l;
      bound_type zero_u;
      bound_type sync_l;
      bound_type sync_u;
   } bounds_type;

   // Everything the datapath needs from the register file.
   typedef struct packed {
      bounds_type bounds;
      width_type  eom_gap;
      width_type  row_gap;
   } cfg_type;

   // Zero-extend a sample count into the signed bound width.
   function automatic bound_type ext(input width_type x);
      return bound_type'({2'b00, x});
   endfunction

   // Midpoint threshold: (a + b) / 2 + 1.
   function automatic bound_type mid(input width_type a, input width_type b);
      logic [WIDTH_BITS:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return bound_type'({2'b00, sum[WIDTH_BITS:1]}) + bound_type'(1);
   endfunction

   // Derive the class bounds from the configured widths.
   function automatic bounds_type make_bounds(input width_type s, input width_type l,
                                              input width_type y, input width_type t);
      bounds_type b;
      bound_type  m_sl;
      bound_type  m_sy;
      bound_type  m_ly;
      m_sl = mid(s, l);
      m_sy = mid(s, y);
      m_ly = mid(l, y);
      b.sync_l = '0;
      b.sync_u = '0;
      if (t != '0) begin
         // Windows of nominal plus or minus the tolerance.
         b.one_l  = ext(s) - ext(t);
         b.one_u  = ext(s) + ext(t);
         b.zero_l = ext(l) - ext(t);
         b.zero_u = ext(l) + ext(t);
         if (y != '0) begin
            b.sync_l = ext(y) - ext(t);
            b.sync_u = ext(y) + ext(t);
         end
      end else if (y == '0) begin
         b.one_l  = '0;
         b.one_u  = m_sl;
         b.zero_l = m_sl - bound_type'(1);
         b.zero_u = BOUND_MAX;
      end else if (y < s) begin
         // Sync below the short pulse.
         b.sync_l = '0;
         b.sync_u = m_sy;
         b.one_l  = m_sy - bound_type'(1);
         b.one_u  = m_sl;
         b.zero_l = m_sl - bound_type'(1);
         b.zero_u = BOUND_MAX;
      end else if (y < l) begin
         // Sync between the short and the long pulse.
         b.one_l  = '0;
         b.one_u  = m_sy;
         b.sync_l = m_sy - bound_type'(1);
         b.sync_u = m_ly;
         b.zero_l = m_ly - bound_type'(1);
         b.zero_u = BOUND_MAX;
      end else begin
         // Sync above the long pulse.
         b.one_l  = '0;
         b.one_u  = m_sl;
         b.zero_l = m_sl - bound_type'(1);
         b.zero_u = m_ly;
         b.sync_l = m_ly - bound_type'(1);
         b.sync_u = BOUND_MAX;
      end
      return b;
   endfunction

endpackage

### src/pwd_csr.sv
// Configuration registers of the pulse-width demodulator and the registered
// class bounds derived from them. Depends on pwd_pkg.
module pwd_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_en,
   input  logic [pwd_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  pwd_pkg::width_type                  csr_wdata,
   output pwd_pkg::cfg_type                    cfg
);

   pwd_pkg::width_type  short_ff, short_in;
   pwd_pkg::width_type  long_ff, long_in;
   pwd_pkg::width_type  sync_ff, sync_in;
   pwd_pkg::width_type  tol_ff, tol_in;
   pwd_pkg::width_type  eom_gap_ff, eom_gap_in;
   pwd_pkg::width_type  row_gap_ff, row_gap_in;
   pwd_pkg::bounds_type bounds_ff, bounds_in;

   // Register write decode; indexes beyond the list are dropped.
   always_comb begin
      short_in   = short_ff;
      long_in    = long_ff;
      sync_in    = sync_ff;
      tol_in     = tol_ff;
      eom_gap_in = eom_gap_ff;
      row_gap_in = row_gap_ff;
      if (csr_write_en) begin
         case (pwd_pkg::csr_index_type'(csr_index))
            pwd_pkg::CSR_SHORT_WIDTH: short_in   = csr_wdata;
            pwd_pkg::CSR_LONG_WIDTH:  long_in    = csr_wdata;
            pwd_pkg::CSR_SYNC_WIDTH:  sync_in    = csr_wdata;
            pwd_pkg::CSR_TOLERANCE:   tol_in     = csr_wdata;
            pwd_pkg::CSR_EOM_GAP:     eom_gap_in = csr_wdata;
            pwd_pkg::CSR_ROW_GAP:     row_gap_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // The bounds follow the register values that take effect at the same edge.
   always_comb begin
      bounds_in = pwd_pkg::make_bounds(short_in, long_in, sync_in, tol_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         short_ff   <= '0;
         long_ff    <= '0;
         sync_ff    <= '0;
         tol_ff     <= '0;
         eom_gap_ff <= '0;
         row_gap_ff <= '0;
         bounds_ff  <= pwd_pkg::make_bounds('0, '0, '0, '0);
      end else begin
         short_ff   <= short_in;
         long_ff    <= long_in;
         sync_ff    <= sync_in;
         tol_ff     <= tol_in;
         eom_gap_ff <= eom_gap_in;
         row_gap_ff <= row_gap_in;
         bounds_ff  <= bounds_in;
      end
   end

   assign cfg.bounds  = bounds_ff;
   assign cfg.eom_gap = eom_gap_ff;
   assign cfg.row_gap = row_gap_ff;

endmodule

### src/pwm_pulse_width_demodulator_unit.sv
// Top level of the pulse-width demodulator: input register, pulse and gap
// classification, row flags and a two-entry result queue.
// Depends on pwd_pkg and pwd_csr.
//
// Usage:
// - The req channel carries one pulse/gap width pair per transaction. The rsp
//   channel returns zero, one or two events per pair; last_of_run marks the
//   final event of a pair. Both channels use valid/ready.
// - The csr port is a write-only register file (write enable, index, data); the
//   user must write it only while idle; the block does not enforce it.
//   Class bounds update at the write edge; a pair may follow in the next cycle.
// - Path: an accepted pair is held in the input register, classified, and its
//   events are written into the result queue, whose head is offered on rsp.
// - Throughput: one pair per cycle while each pair yields at most one event
//   and the receiver is ready. A pair with two events needs the single result
//   port twice, which can hold up later pairs; the two-entry queue lets the
//   two events of a pair leave back to back.
// - When the receiver stalls, the queue fills and then the input register
//   holds its pair; req_ready drops once the input register holds a pair
//   whose events do not fit into the queue.
// - Reset clears the csr registers, in_valid, the row flags and the queue.
module pwm_pulse_width_demodulator_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  pwd_pkg::req_type                   req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output pwd_pkg::rsp_type                   rsp_data,
   input  logic                               csr_write_en,
   input  logic [pwd_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  pwd_pkg::width_type                 csr_wdata
);

   pwd_pkg::cfg_type  cfg;

   pwd_pkg::req_type  in_ff, in_in;
   logic              in_valid_ff, in_valid_in;
   logic              row_open_ff, row_open_in;
   logic              row_has_ff, row_has_in;
   pwd_pkg::rsp_type  q_ff [2];
   pwd_pkg::rsp_type  q_in [2];
   logic [1:0]        q_cnt_ff, q_cnt_in;

   pwd_pkg::bound_type p_ext;
   logic              pulse_ev;
   pwd_pkg::event_kind_type pulse_kind;
   logic              open1, has1;
   logic              gap_eom, gap_row;
   logic              gap_ev;
   logic              open2, has2;
   pwd_pkg::rsp_type  ev0, ev1;
   logic [1:0]        n_ev;
   logic              pop;
   logic [1:0]        cnt_after;
   logic              fits;
   logic              retire;

   pwd_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg)
   );

   // Pulse classification against the registered bounds.
   always_comb begin
      p_ext      = pwd_pkg::ext(in_ff.pulse_width);
      pulse_ev   = 1'b1;
      pulse_kind = pwd_pkg::EV_ROW;
      open1      = 1'b1;
      has1       = 1'b0;
      if (p_ext > cfg.bounds.one_l && p_ext < cfg.bounds.one_u) begin
         pulse_kind = pwd_pkg::EV_ONE;
         has1       = 1'b1;
      end else if (p_ext > cfg.bounds.zero_l && p_ext < cfg.bounds.zero_u) begin
         pulse_kind = pwd_pkg::EV_ZERO;
         has1       = 1'b1;
      end else if (p_ext > cfg.bounds.sync_l && p_ext < cfg.bounds.sync_u) begin
         pulse_kind = pwd_pkg::EV_SYNC;
      end else if (p_ext <= cfg.bounds.one_l) begin
         // A short spike is ignored and leaves the flags alone.
         pulse_ev = 1'b0;
         open1    = row_open_ff;
         has1     = row_has_ff;
      end
   end

   // Gap check: end of message has priority over a new row.
   always_comb begin
      gap_eom = (in_ff.final_pulse || (in_ff.gap_width > cfg.eom_gap)) && open1;
      gap_row = !gap_eom && (cfg.row_gap != '0) &&
                (in_ff.gap_width > cfg.row_gap) && open1 && has1;
      gap_ev  = gap_eom || gap_row;
      open2   = gap_eom ? 1'b0 : open1;
      has2    = gap_ev ? 1'b0 : has1;
   end

   // Assemble the events of this transaction in order.
   always_comb begin
      ev0.event_kind  = pulse_kind;
      ev0.last_of_run = !gap_ev;
      ev1.event_kind  = gap_eom ? pwd_pkg::EV_EOM : pwd_pkg::EV_ROW;
      ev1.last_of_run = 1'b1;
      n_ev            = {1'b0, pulse_ev} + {1'b0, gap_ev};
      if (!pulse_ev) begin
         ev0 = ev1;
      end
   end

   // Handshake: retire the held transaction when its events fit after this pop.
   always_comb begin
      pop       = (q_cnt_ff != 2'd0) && rsp_ready;
      cnt_after = q_cnt_ff - {1'b0, pop};
      fits      = ({1'b0, cnt_after} + {1'b0, n_ev}) <= 3'd2;
      retire    = in_valid_ff && fits;
      req_ready = !in_valid_ff || retire;
   end

   // Input register and row flags.
   always_comb begin
      in_in       = in_ff;
      in_valid_in = in_valid_ff;
      row_open_in = row_open_ff;
      row_has_in  = row_has_ff;
      if (retire) begin
         in_valid_in = 1'b0;
         row_open_in = open2;
         row_has_in  = has2;
      end
      if (req_valid && req_ready) begin
         in_in       = req_data;
         in_valid_in = 1'b1;
      end
   end

   // Result queue: shift out on a pop, then append the new events.
   always_comb begin
      q_in[0]  = q_ff[0];
      q_in[1]  = q_ff[1];
      q_cnt_in = cnt_after;
      if (pop) begin
         q_in[0] = q_ff[1];
      end
      if (retire) begin
         q_cnt_in = cnt_after + n_ev;
         if (n_ev != 2'd0) begin
            q_in[cnt_after[0]] = ev0;
         end
         if (n_ev == 2'd2) begin
            q_in[1] = ev1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         row_open_ff <= 1'b0;
         row_has_ff  <= 1'b0;
         q_cnt_ff    <= 2'd0;
      end else begin
         in_valid_ff <= in_valid_in;
         row_open_ff <= row_open_in;
         row_has_ff  <= row_has_in;
         q_cnt_ff    <= q_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      in_ff   <= in_in;
      q_ff[0] <= q_in[0];
      q_ff[1] <= q_in[1];
   end

   assign rsp_valid = q_cnt_ff != 2'd0;
   assign rsp_data  = q_ff[0];

`ifndef SYNTHESIS
   // A row can only hold bits while it is open.
   a_bits_need_row: assert property (@(posedge clock) disable iff (reset)
      row_has_ff |-> row_open_ff)
      else $error("row_has_bits set without an open row");

   // An end of message closes the row.
   a_eom_closes: assert property (@(posedge clock) disable iff (reset)
      retire && gap_eom |=> !row_open_ff && !row_has_ff)
      else $error("row still open after end of message");

   // With an empty queue a waiting transaction is always retired.
   a_empty_progress: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && (q_cnt_ff == 2'd0) |-> retire)
      else $error("input stalled with an empty result queue");

   // An event that is not the last of its run always has its partner queued.
   a_run_complete: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last_of_run |-> q_cnt_ff == 2'd2)
      else $error("first event of a pair without its second event");
`endif

endmodule
